// File: design/ycc2rgb_pkg.sv
// Shared types, register codes and fixed-point constants for the YCbCr to RGB converter.
// No dependencies. Every other design file refers to this package by scoped names.
`default_nettype none

package ycc2rgb_pkg;

  // Field and datapath widths
  localparam int SAMPLE_W    = 16;  // input sample word
  localparam int RGB_W       = 13;  // output channel field
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 2;
  localparam int NUM_STAGES  = 5;

  localparam int VAL_W       = 10;  // extracted sample value
  localparam int HALF_W      = 9;   // den/2
  localparam int NUM_W       = 26;  // |v-off|*2^16 + den/2
  localparam int RECIP_W     = 29;  // ceil(2^36/den)
  localparam int RECIP_SHIFT = 36;
  localparam int PROD_N_W    = NUM_W + RECIP_W;
  localparam int MAG_W       = 19;
  localparam int NORM_W      = MAG_W + 1;  // signed Q16 sample
  localparam int COEF_W      = 17;
  localparam int PROD_W      = NORM_W + COEF_W + 1;
  localparam int ACC_W       = 40;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MATRIX  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMITED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FORMAT  = 2'd2;

  // matrix_standard codes
  localparam logic [1:0] MAT_BT709  = 2'd0;
  localparam logic [1:0] MAT_BT601  = 2'd1;
  localparam logic [1:0] MAT_BT2020 = 2'd2;

  // sample_format codes
  localparam logic [1:0] FMT_8BIT     = 2'd0;
  localparam logic [1:0] FMT_10B_LOW  = 2'd1;
  localparam logic [1:0] FMT_10B_HIGH = 2'd2;

  // Reciprocals: floor(N*ceil(2^36/d) >> 36) == floor(N/d) for every N < 2^26
  localparam longint unsigned PW = 64'd1 << RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] RECIP_219  = RECIP_W'((PW + 64'd218)  / 64'd219);
  localparam logic [RECIP_W-1:0] RECIP_224  = RECIP_W'((PW + 64'd223)  / 64'd224);
  localparam logic [RECIP_W-1:0] RECIP_255  = RECIP_W'((PW + 64'd254)  / 64'd255);
  localparam logic [RECIP_W-1:0] RECIP_876  = RECIP_W'((PW + 64'd875)  / 64'd876);
  localparam logic [RECIP_W-1:0] RECIP_896  = RECIP_W'((PW + 64'd895)  / 64'd896);
  localparam logic [RECIP_W-1:0] RECIP_1023 = RECIP_W'((PW + 64'd1022) / 64'd1023);

  typedef struct packed {
    logic [1:0] matrix_standard;
    logic       limited_range;
    logic [1:0] sample_format;
  } cfg_t;

  typedef struct packed {
    logic [HALF_W-1:0]  half;
    logic [RECIP_W-1:0] recip;
  } norm_const_t;

  typedef struct packed {
    logic [COEF_W-1:0] cr_r;
    logic [COEF_W-1:0] cb_b;
    logic [COEF_W-1:0] cb_g;
    logic [COEF_W-1:0] cr_g;
  } coef_t;

  function automatic norm_const_t norm_const(input logic ten, input logic lim,
                                             input logic chroma);
    norm_const_t c;
    if (ten) begin
      if (!lim) c = '{half: 9'd511, recip: RECIP_1023};
      else if (chroma) c = '{half: 9'd448, recip: RECIP_896};
      else c = '{half: 9'd438, recip: RECIP_876};
    end else begin
      if (!lim) c = '{half: 9'd127, recip: RECIP_255};
      else if (chroma) c = '{half: 9'd112, recip: RECIP_224};
      else c = '{half: 9'd109, recip: RECIP_219};
    end
    return c;
  endfunction

  // Q16 inverse-matrix coefficients; unused code falls back to BT.709
  function automatic coef_t mat_coef(input logic [1:0] std);
    coef_t c;
    unique case (std)
      MAT_BT601:  c = '{cr_r: 17'd91881, cb_b: 17'd116130, cb_g: 17'd22553, cr_g: 17'd46802};
      MAT_BT2020: c = '{cr_r: 17'd96639, cb_b: 17'd123299, cb_g: 17'd10784, cr_g: 17'd37444};
      default:    c = '{cr_r: 17'd103206, cb_b: 17'd121609, cb_g: 17'd12276, cr_g: 17'd30679};
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: design/ycc2rgb_norm.sv
// One channel of range normalization: sample extract, offset, divide by a constant.
// Two pipeline stages. Uses ycc2rgb_pkg.
`default_nettype none

module ycc2rgb_norm (
  input  wire logic                              clk,
  input  wire logic                              en_a,
  input  wire logic                              en_b,
  input  wire ycc2rgb_pkg::cfg_t                 cfg,
  input  wire logic                              is_chroma,
  input  wire logic [ycc2rgb_pkg::SAMPLE_W-1:0]  sample,
  output logic signed [ycc2rgb_pkg::NORM_W-1:0]  q_r
);

  logic [ycc2rgb_pkg::VAL_W-1:0]    val;
  logic                             ten;
  logic [ycc2rgb_pkg::VAL_W-1:0]    off;
  logic signed [ycc2rgb_pkg::VAL_W:0] diff;
  logic [ycc2rgb_pkg::VAL_W-1:0]    mag;
  ycc2rgb_pkg::norm_const_t         nc;

  logic [ycc2rgb_pkg::NUM_W-1:0]    num_r, num_nxt;
  logic [ycc2rgb_pkg::RECIP_W-1:0]  recip_r;
  logic                             neg_r;

  logic [ycc2rgb_pkg::PROD_N_W-1:0] prod;
  logic [ycc2rgb_pkg::MAG_W-1:0]    qmag;
  logic signed [ycc2rgb_pkg::NORM_W-1:0] q_nxt;

  always_comb begin
    unique case (cfg.sample_format)
      ycc2rgb_pkg::FMT_10B_LOW: begin
        val = sample[9:0];
        ten = 1'b1;
      end
      ycc2rgb_pkg::FMT_10B_HIGH: begin
        val = sample[15:6];
        ten = 1'b1;
      end
      default: begin
        val = {2'b00, sample[7:0]};
        ten = 1'b0;
      end
    endcase

    if (ten) off = is_chroma ? 10'd512 : (cfg.limited_range ? 10'd64 : 10'd0);
    else     off = is_chroma ? 10'd128 : (cfg.limited_range ? 10'd16 : 10'd0);

    diff = $signed({1'b0, val}) - $signed({1'b0, off});
    mag  = diff[ycc2rgb_pkg::VAL_W] ? ycc2rgb_pkg::VAL_W'(-diff)
                                    : diff[ycc2rgb_pkg::VAL_W-1:0];
    nc   = ycc2rgb_pkg::norm_const(ten, cfg.limited_range, is_chroma);
    // round half away from zero: work on the magnitude, sign applied later
    num_nxt = {mag, 16'd0} + ycc2rgb_pkg::NUM_W'(nc.half);
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      num_r   <= num_nxt;
      recip_r <= nc.recip;
      neg_r   <= diff[ycc2rgb_pkg::VAL_W];
    end
  end

  always_comb begin
    prod  = num_r * recip_r;
    qmag  = prod[ycc2rgb_pkg::RECIP_SHIFT +: ycc2rgb_pkg::MAG_W];
    q_nxt = neg_r ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
  end

  always_ff @(posedge clk) begin
    if (en_b) q_r <= q_nxt;
  end

endmodule

`default_nettype wire

// File: design/ycc2rgb_matrix.sv
// Inverse color matrix: registered products, then registered Q32 channel sums.
// Two pipeline stages. Uses ycc2rgb_pkg.
`default_nettype none

module ycc2rgb_matrix (
  input  wire logic                                clk,
  input  wire logic                                en_c,
  input  wire logic                                en_d,
  input  wire ycc2rgb_pkg::cfg_t                   cfg,
  input  wire logic signed [ycc2rgb_pkg::NORM_W-1:0] y,
  input  wire logic signed [ycc2rgb_pkg::NORM_W-1:0] cb,
  input  wire logic signed [ycc2rgb_pkg::NORM_W-1:0] cr,
  output logic signed [ycc2rgb_pkg::ACC_W-1:0]     acc_r_r,
  output logic signed [ycc2rgb_pkg::ACC_W-1:0]     acc_g_r,
  output logic signed [ycc2rgb_pkg::ACC_W-1:0]     acc_b_r
);

  ycc2rgb_pkg::coef_t coef;
  logic signed [ycc2rgb_pkg::ACC_W-1:0]  yy_r;
  logic signed [ycc2rgb_pkg::PROD_W-1:0] p_rr_r, p_bb_r, p_bg_r, p_rg_r;

  assign coef = ycc2rgb_pkg::mat_coef(cfg.matrix_standard);

  always_ff @(posedge clk) begin
    if (en_c) begin
      yy_r   <= ycc2rgb_pkg::ACC_W'(y) <<< 16;
      p_rr_r <= cr * $signed({1'b0, coef.cr_r});
      p_bb_r <= cb * $signed({1'b0, coef.cb_b});
      p_bg_r <= cb * $signed({1'b0, coef.cb_g});
      p_rg_r <= cr * $signed({1'b0, coef.cr_g});
    end
  end

  always_ff @(posedge clk) begin
    if (en_d) begin
      acc_r_r <= yy_r + ycc2rgb_pkg::ACC_W'(p_rr_r);
      acc_g_r <= yy_r - ycc2rgb_pkg::ACC_W'(p_bg_r) - ycc2rgb_pkg::ACC_W'(p_rg_r);
      acc_b_r <= yy_r + ycc2rgb_pkg::ACC_W'(p_bb_r);
    end
  end

endmodule

`default_nettype wire

// File: design/ycc2rgb_out.sv
// Output stage: round Q32 accumulators to OUT_FRAC_BITS, clamp to 0..1.0, register.
// One pipeline stage. Uses ycc2rgb_pkg.
`default_nettype none

module ycc2rgb_out #(
  parameter int OUT_FRAC_BITS = 12
) (
  input  wire logic                                  clk,
  input  wire logic                                  en_e,
  input  wire logic signed [ycc2rgb_pkg::ACC_W-1:0]  acc_r,
  input  wire logic signed [ycc2rgb_pkg::ACC_W-1:0]  acc_g,
  input  wire logic signed [ycc2rgb_pkg::ACC_W-1:0]  acc_b,
  output logic [ycc2rgb_pkg::RGB_W-1:0]              red_r,
  output logic [ycc2rgb_pkg::RGB_W-1:0]              green_r,
  output logic [ycc2rgb_pkg::RGB_W-1:0]              blue_r
);

  localparam int SHIFT = 32 - OUT_FRAC_BITS;
  localparam logic [ycc2rgb_pkg::ACC_W-1:0] ROUND = ycc2rgb_pkg::ACC_W'(1) << (SHIFT - 1);
  localparam logic [ycc2rgb_pkg::ACC_W-1:0] FULL  = ycc2rgb_pkg::ACC_W'(1) << OUT_FRAC_BITS;

  function automatic logic [ycc2rgb_pkg::RGB_W-1:0] to_out(
      input logic signed [ycc2rgb_pkg::ACC_W-1:0] acc);
    logic [ycc2rgb_pkg::ACC_W-1:0] sh;
    logic [ycc2rgb_pkg::ACC_W-1:0] sat;
    sh  = ($unsigned(acc) + ROUND) >> SHIFT;
    sat = (sh > FULL) ? FULL : sh;
    // non-positive accumulators clamp to black
    if (acc[ycc2rgb_pkg::ACC_W-1] || acc == '0) sat = '0;
    return sat[ycc2rgb_pkg::RGB_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en_e) begin
      red_r   <= to_out(acc_r);
      green_r <= to_out(acc_g);
      blue_r  <= to_out(acc_b);
    end
  end

endmodule

`default_nettype wire

// File: design/ycbcr_to_rgb_converter_core.sv
// YCbCr to RGB converter, top level: config registers, stage valids and stall chain.
// Instantiates ycc2rgb_norm (x3), ycc2rgb_matrix, ycc2rgb_out. Uses ycc2rgb_pkg.
//
// Converts one Y/Cb/Cr triple per transaction to R/G/B in unsigned fixed point with
// OUT_FRAC_BITS fraction bits (4096 = 1.0 at the default), clamped to 0..1.0.
// Throughput is one pixel per clock while out_tready does not stall the output. The
// pipe has five register stages, the last of which drives out_tvalid: two for
// normalization (offset, then a reciprocal multiply), two for the matrix (products,
// then sums), one for round and clamp. Each stage advances when it is empty or the
// stage after it moves, so bubbles are squeezed out and the input keeps accepting
// while a result waits at the output until the stages behind it have filled. Format
// and range settings apply to items accepted afterwards, the matrix standard to
// items reaching the products afterwards; write it only while the pipe is empty.
`default_nettype none

module ycbcr_to_rgb_converter_core #(
  parameter int OUT_FRAC_BITS = 12
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  // cfg: index 0 matrix_standard, 1 limited_range, 2 sample_format
  input  wire logic                                   cfg_wr_en,
  input  wire logic [ycc2rgb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [ycc2rgb_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  wire logic                                   in_tvalid,
  output logic                                        in_tready,
  // [15:0] luma_sample, [31:16] blue_diff_sample, [47:32] red_diff_sample
  input  wire logic [ycc2rgb_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                        out_tvalid,
  input  wire logic                                   out_tready,
  // [12:0] red_out, [25:13] green_out, [38:26] blue_out, [39] zero
  output logic [ycc2rgb_pkg::OUT_TDATA_W-1:0]         out_tdata
);

  localparam int NS = ycc2rgb_pkg::NUM_STAGES;

  ycc2rgb_pkg::cfg_t cfg_r;
  logic [NS-1:0] valid_r, valid_nxt;
  logic [NS-1:0] en;

  logic signed [ycc2rgb_pkg::NORM_W-1:0] y_q, cb_q, cr_q;
  logic signed [ycc2rgb_pkg::ACC_W-1:0]  acc_r, acc_g, acc_b;
  logic [ycc2rgb_pkg::RGB_W-1:0]         red, green, blue;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.matrix_standard <= ycc2rgb_pkg::MAT_BT709;
      cfg_r.limited_range   <= 1'b1;
      cfg_r.sample_format   <= ycc2rgb_pkg::FMT_8BIT;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        ycc2rgb_pkg::REG_MATRIX:  cfg_r.matrix_standard <= cfg_wdata;
        ycc2rgb_pkg::REG_LIMITED: cfg_r.limited_range   <= cfg_wdata[0];
        ycc2rgb_pkg::REG_FORMAT:  cfg_r.sample_format   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // A stage loads when empty or when its contents move on.
  always_comb begin
    en[NS-1] = !valid_r[NS-1] || out_tready;
    for (int i = NS - 2; i >= 0; i--) en[i] = !valid_r[i] || en[i+1];

    valid_nxt = valid_r;
    if (en[0]) valid_nxt[0] = in_tvalid;
    for (int i = 1; i < NS; i++) begin
      if (en[i]) valid_nxt[i] = valid_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= '0;
    else        valid_r <= valid_nxt;
  end

  assign in_tready  = en[0];
  assign out_tvalid = valid_r[NS-1];
  assign out_tdata  = {1'b0, blue, green, red};

  ycc2rgb_norm u_norm_y (
    .clk       (clk),
    .en_a      (en[0]),
    .en_b      (en[1]),
    .cfg       (cfg_r),
    .is_chroma (1'b0),
    .sample    (in_tdata[15:0]),
    .q_r       (y_q)
  );

  ycc2rgb_norm u_norm_cb (
    .clk       (clk),
    .en_a      (en[0]),
    .en_b      (en[1]),
    .cfg       (cfg_r),
    .is_chroma (1'b1),
    .sample    (in_tdata[31:16]),
    .q_r       (cb_q)
  );

  ycc2rgb_norm u_norm_cr (
    .clk       (clk),
    .en_a      (en[0]),
    .en_b      (en[1]),
    .cfg       (cfg_r),
    .is_chroma (1'b1),
    .sample    (in_tdata[47:32]),
    .q_r       (cr_q)
  );

  ycc2rgb_matrix u_matrix (
    .clk     (clk),
    .en_c    (en[2]),
    .en_d    (en[3]),
    .cfg     (cfg_r),
    .y       (y_q),
    .cb      (cb_q),
    .cr      (cr_q),
    .acc_r_r (acc_r),
    .acc_g_r (acc_g),
    .acc_b_r (acc_b)
  );

  ycc2rgb_out #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_out (
    .clk     (clk),
    .en_e    (en[4]),
    .acc_r   (acc_r),
    .acc_g   (acc_g),
    .acc_b   (acc_b),
    .red_r   (red),
    .green_r (green),
    .blue_r  (blue)
  );

endmodule

`default_nettype wire

// File: design/ycc2rgb_chk.sv
// Port-level checker for ycbcr_to_rgb_converter_core, attached by the bind below.
// Uses ycc2rgb_pkg for port widths.
`default_nettype none

module ycc2rgb_chk #(
  parameter int OUT_FRAC_BITS = 12
) (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_tready,
  input wire logic                                out_tvalid,
  input wire logic                                out_tready,
  input wire logic [ycc2rgb_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam bit CHECK_RANGE = (OUT_FRAC_BITS <= 12);
  localparam int FULL        = 1 << OUT_FRAC_BITS;

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output transaction changed while stalled");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // an empty or draining output stage never backs up the input
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid || out_tready) |-> in_tready)
    else $error("input stalled with free output");

  // channels stay within 0..1.0; checked only when OUT_FRAC_BITS is 12 or less
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !CHECK_RANGE || (int'(out_tdata[12:0]) <= FULL &&
                   int'(out_tdata[25:13]) <= FULL && int'(out_tdata[38:26]) <= FULL))
    else $error("output channel above full scale");

  // padding bit stays clear
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[39])
    else $error("out_tdata padding bit set");

endmodule

bind ycbcr_to_rgb_converter_core ycc2rgb_chk #(
  .OUT_FRAC_BITS (OUT_FRAC_BITS)
) u_ycc2rgb_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// File: bench/ycc2rgb_checker.sv
// Scoreboard for the YCbCr to RGB converter: watches the cfg port and both stream channels,
// predicts R/G/B for each accepted pixel and compares them in order. Uses ycc2rgb_pkg.
module ycc2rgb_checker #(
  parameter int OUT_FRAC_BITS = 12
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [ycc2rgb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ycc2rgb_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire logic                                 in_tvalid,
  input  wire logic                                 in_tready,
  // [15:0] luma_sample, [31:16] blue_diff_sample, [47:32] red_diff_sample
  input  wire logic [ycc2rgb_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  wire logic                                 out_tvalid,
  input  wire logic                                 out_tready,
  // [12:0] red_out, [25:13] green_out, [38:26] blue_out, [39] zero
  input  wire logic [ycc2rgb_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output int                                        fail_count,
  output int                                        outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import ycc2rgb_pkg::*;

  localparam int     RND_SHIFT  = 32 - OUT_FRAC_BITS;
  localparam longint FULL_SCALE = longint'(1) << OUT_FRAC_BITS;

  typedef struct {
    logic [RGB_W-1:0]      red;
    logic [RGB_W-1:0]      green;
    logic [RGB_W-1:0]      blue;
    logic [IN_TDATA_W-1:0] ycc;
  } rgb_expect_t;

  logic [1:0]  matrix_q  = MAT_BT709;
  logic        limited_q = 1'b1;
  logic [1:0]  format_q  = FMT_8BIT;
  rgb_expect_t rgb_expected_q[$];
  int          error_count = 0;

  assign fail_count = error_count;

  // Sample word to signed Q16: nominal Y maps to [0,1], chroma centered on zero
  function automatic longint norm_q16(input logic [15:0] word, input bit chroma);
    longint v, off, den, num;
    bit ten;
    ten = (format_q == FMT_10B_LOW) || (format_q == FMT_10B_HIGH);
    case (format_q)
      FMT_10B_LOW:  v = longint'(word[9:0]);
      FMT_10B_HIGH: v = longint'(word[15:6]);
      default:      v = longint'(word[7:0]);
    endcase
    if (ten) begin
      off = chroma ? 512 : (limited_q ? 64 : 0);
      den = !limited_q ? 1023 : (chroma ? 896 : 876);
    end else begin
      off = chroma ? 128 : (limited_q ? 16 : 0);
      den = !limited_q ? 255 : (chroma ? 224 : 219);
    end
    num = (v - off) * 65536;
    // round half away from zero
    if (num >= 0) return (num + den / 2) / den;
    return -((-num + den / 2) / den);
  endfunction

  function automatic logic [RGB_W-1:0] clamp_channel(input longint acc);
    longint r;
    if (acc <= 0) return '0;
    r = (acc + (longint'(1) << (RND_SHIFT - 1))) >>> RND_SHIFT;
    if (r > FULL_SCALE) r = FULL_SCALE;
    return r[RGB_W-1:0];
  endfunction

  function automatic rgb_expect_t predict_rgb(input logic [IN_TDATA_W-1:0] pix);
    longint y, cb, cr, cr_r, cb_b, cb_g, cr_g;
    rgb_expect_t res;
    case (matrix_q)
      MAT_BT601: begin
        cr_r = 91881;  cb_b = 116130; cb_g = 22553; cr_g = 46802;
      end
      MAT_BT2020: begin
        cr_r = 96639;  cb_b = 123299; cb_g = 10784; cr_g = 37444;
      end
      default: begin
        cr_r = 103206; cb_b = 121609; cb_g = 12276; cr_g = 30679;
      end
    endcase
    y  = norm_q16(pix[15:0], 1'b0) * 65536;
    cb = norm_q16(pix[31:16], 1'b1);
    cr = norm_q16(pix[47:32], 1'b1);
    res.red   = clamp_channel(y + cr_r * cr);
    res.green = clamp_channel(y - cb_g * cb - cr_g * cr);
    res.blue  = clamp_channel(y + cb_b * cb);
    res.ycc   = pix;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    error_count++;
  endtask

  always @(posedge clk) begin
    rgb_expect_t want;
    logic [RGB_W-1:0] got_r, got_g, got_b;
    if (!rst_n) begin
      matrix_q  = MAT_BT709;
      limited_q = 1'b1;
      format_q  = FMT_8BIT;
      rgb_expected_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got_r = out_tdata[RGB_W-1:0];
        got_g = out_tdata[2*RGB_W-1:RGB_W];
        got_b = out_tdata[3*RGB_W-1:2*RGB_W];
        if (rgb_expected_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending, tdata 0x%010h", out_tdata));
        end else begin
          want = rgb_expected_q.pop_front();
          if (got_r !== want.red)
            report_mismatch($sformatf("red %0d, want %0d (ycc 0x%012h)",
                                      got_r, want.red, want.ycc));
          if (got_g !== want.green)
            report_mismatch($sformatf("green %0d, want %0d (ycc 0x%012h)",
                                      got_g, want.green, want.ycc));
          if (got_b !== want.blue)
            report_mismatch($sformatf("blue %0d, want %0d (ycc 0x%012h)",
                                      got_b, want.blue, want.ycc));
          if (out_tdata[OUT_TDATA_W-1:3*RGB_W] !== '0)
            report_mismatch($sformatf("pad bits set, tdata 0x%010h", out_tdata));
        end
      end
      // predict with the settings in force before any write at this edge
      if (in_tvalid && in_tready) rgb_expected_q.push_back(predict_rgb(in_tdata));
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_MATRIX:  matrix_q  = cfg_wdata;
          REG_LIMITED: limited_q = cfg_wdata[0];
          REG_FORMAT:  format_q  = cfg_wdata;
          default: ;
        endcase
      end
    end
    outstanding <= rgb_expected_q.size();
  end

endmodule

// File: bench/tb_top.sv
// Top of the YCbCr to RGB converter bench: clock, reset, cfg writes, pixel stimulus with
// random idling on both channels, and the verdict. Needs ycc2rgb_pkg and ycc2rgb_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ycc2rgb_pkg::*;

  localparam int OUT_FRAC    = 12;
  localparam int CYCLE_LIMIT = 300000;
  localparam int SEGMENTS    = 6;
  localparam int SEG_ITEMS   = 92;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [1:0] MAT_UNUSED = 2'd3;
  localparam logic [1:0] FMT_UNUSED = 2'd3;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;
  logic                   in_tvalid  = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tready = 1'b0;
  wire                    in_tready;
  wire                    out_tvalid;
  wire [OUT_TDATA_W-1:0]  out_tdata;
  int                     fail_count;
  int                     outstanding;

  int          send_idle_pct = 31;
  int          recv_idle_pct = 60;
  int          cycle_count   = 0;
  logic [1:0]  cur_format    = FMT_8BIT;
  logic        cur_limited   = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ycbcr_to_rgb_converter_core #(.OUT_FRAC_BITS(OUT_FRAC)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  ycc2rgb_checker #(.OUT_FRAC_BITS(OUT_FRAC)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("ycbcr_to_rgb_converter_core regression: fail");
    $finish;
  end

  // One transaction on the input channel; in_tready is sampled mid-cycle, where it is settled
  task automatic send_pixel(input logic [IN_TDATA_W-1:0] pix);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= IN_TDATA_W'({$urandom(), $urandom()});
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    do begin
      @(negedge clk);
      taken = in_tready;
      @(posedge clk);
    end while (!taken);
  endtask

  // Hold off the input until every pending pixel has come out, then let the pipe settle
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (NUM_STAGES + 2) @(posedge clk);
  endtask

  // Also pokes the unused index and sets a junk upper bit on limited_range
  task automatic write_config(input logic [1:0] mat, input logic lim, input logic [1:0] fmt);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_MATRIX;
    cfg_wdata <= mat;
    @(posedge clk);
    cfg_index <= REG_LIMITED;
    cfg_wdata <= {1'($urandom_range(1)), lim};
    @(posedge clk);
    cfg_index <= REG_FORMAT;
    cfg_wdata <= fmt;
    @(posedge clk);
    cfg_index <= REG_UNUSED;
    cfg_wdata <= 2'($urandom_range(3));
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_format  = fmt;
    cur_limited = lim;
  endtask

  // Mostly in-range samples with junk in the unused bits; some edges, some raw words
  function automatic logic [15:0] random_word(input bit chroma);
    int unsigned top_val, lo, hi, pick, v;
    bit ten;
    ten     = (cur_format == FMT_10B_LOW) || (cur_format == FMT_10B_HIGH);
    top_val = ten ? 1023 : 255;
    lo      = ten ? 64 : 16;
    hi      = ten ? (chroma ? 960 : 940) : (chroma ? 240 : 235);
    if (!cur_limited) begin
      lo = 0;
      hi = top_val;
    end
    pick = $urandom_range(99);
    if (pick >= 90) return 16'($urandom());
    if (pick < 45) v = $urandom_range(top_val);
    else if (pick < 75) v = $urandom_range(hi, lo);
    else if (pick < 83) v = $urandom_range(3);
    else v = top_val - $urandom_range(3);
    case (cur_format)
      FMT_10B_LOW:  return {6'($urandom()), v[9:0]};
      FMT_10B_HIGH: return {v[9:0], 6'($urandom())};
      default:      return {8'($urandom()), v[7:0]};
    endcase
  endfunction

  initial begin : stimulus
    int idx;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: BT.709, limited, 8-bit; tdata is {cr, cb, y}
    send_pixel({16'd128, 16'd128, 16'd16});
    send_pixel({16'd128, 16'd128, 16'd235});
    send_pixel({16'd240, 16'd240, 16'd235});
    send_pixel({16'd16, 16'd16, 16'd16});
    send_pixel({16'd0, 16'd0, 16'd0});
    send_pixel({16'h00FF, 16'h00FF, 16'h00FF});
    send_pixel({16'hCD80, 16'hAB80, 16'h12EB});
    send_pixel({16'hFFFF, 16'h0000, 16'hFFFF});
    send_pixel({16'd240, 16'd16, 16'd235});
    send_pixel({16'd16, 16'd240, 16'd16});

    drain();
    write_config(MAT_BT601, 1'b0, FMT_10B_LOW);
    send_pixel({16'd512, 16'd512, 16'd0});
    send_pixel({16'd512, 16'd512, 16'd1023});
    send_pixel({16'd0, 16'd1023, 16'd1023});
    send_pixel({16'd1023, 16'd0, 16'd0});
    send_pixel({16'hFE00, 16'h0600, 16'hFC00});

    drain();
    write_config(MAT_BT2020, 1'b1, FMT_10B_HIGH);
    send_pixel({16'h8000, 16'h8000, 16'h1000});
    send_pixel({16'hF000, 16'hF000, 16'hEB00});
    send_pixel({16'hFFFF, 16'hFFFF, 16'hFFFF});
    send_pixel({16'h003F, 16'h003F, 16'h003F});
    send_pixel({16'h0000, 16'h0000, 16'h0000});

    // unused codes fall back to BT.709 and 8-bit
    drain();
    write_config(MAT_UNUSED, 1'b0, FMT_UNUSED);
    send_pixel({16'h0080, 16'h0080, 16'h00FF});
    send_pixel({16'h0080, 16'h0080, 16'h0000});
    send_pixel({16'h3C3C, 16'hA5A5, 16'h5A5A});

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 31;
          recv_idle_pct = 60;
        end
        1: begin
          send_idle_pct = 60;
          recv_idle_pct = 31;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < SEGMENTS; seg++) begin
        idx = phase * SEGMENTS + seg;
        drain();
        write_config(2'(idx % 4), 1'((idx / 3) % 2), 2'((idx / 2) % 4));
        for (int n = 0; n < SEG_ITEMS; n++) begin
          if (idx == 3 && n == SEG_ITEMS / 2) drain();
          send_pixel({random_word(1'b1), random_word(1'b1), random_word(1'b0)});
        end
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("ycbcr_to_rgb_converter_core regression: pass");
    end else begin
      $display("ycbcr_to_rgb_converter_core regression: fail");
    end
    $finish;
  end

endmodule

// File: ycbcr_to_rgb_converter_core.f
design/ycc2rgb_pkg.sv
design/ycc2rgb_norm.sv
design/ycc2rgb_matrix.sv
design/ycc2rgb_out.sv
design/ycbcr_to_rgb_converter_core.sv
design/ycc2rgb_chk.sv
bench/ycc2rgb_checker.sv
bench/tb_top.sv
